>>> rtl/core/word_mask_filter_defines.svh
// Assertion macros shared by the word mask filter RTL.
// Depends on nothing; the asserting module provides clock and reset.
`ifndef WORD_MASK_FILTER_DEFINES_SVH
`define WORD_MASK_FILTER_DEFINES_SVH

// Clocked property, masked while reset is high.
`define WMF_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Condition that must never be true.
`define WMF_NEVER(lbl, cond, msg) \
   `WMF_ASSERT(lbl, !(cond), msg)

`endif

>>> rtl/core/wmf_pkg.sv
// Shared types, constants and byte helpers for the word mask filter.
// No dependencies.
`default_nettype none

package wmf_pkg;

   localparam int MAX_WORD      = 8;
   localparam int DICT_ENTRIES  = 4;
   localparam int NUM_DICT_REGS = 4;
   localparam int DICT_W        = 64;
   localparam int DICT_BYTES    = DICT_W / 8;
   localparam int CSR_IDX_W     = 3;

   localparam int MATCH_COUNT = (DICT_ENTRIES < NUM_DICT_REGS) ? DICT_ENTRIES : NUM_DICT_REGS;
   localparam int ENT_W       = (MATCH_COUNT > 1) ? $clog2(MATCH_COUNT) : 1;
   localparam int IDX_W       = (MAX_WORD > 1) ? $clog2(MAX_WORD) : 1;
   localparam int LEN_W       = $clog2(MAX_WORD + 1);
   localparam int DLEN_W      = $clog2(DICT_BYTES + 1);

   // Register indexes on the csr port
   localparam logic [CSR_IDX_W-1:0] CSR_DICT_0 = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MASK   = 3'd4;

   localparam logic [7:0] CHAR_SPACE   = 8'h20;
   localparam logic [7:0] CHAR_NEWLINE = 8'h0A;

   typedef logic [7:0]                      byte_type;
   typedef logic [MAX_WORD-1:0][7:0]        word_buf_type;
   typedef logic [NUM_DICT_REGS-1:0][DICT_W-1:0] dict_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MATCH,
      ST_WORD,
      ST_TAIL,
      ST_NL
   } wmf_state_type;

   // Control into and status out of the match unit
   typedef struct packed {
      logic start;
   } match_ctrl_type;

   typedef struct packed {
      logic busy;
      logic done;
      logic hit;
   } match_stat_type;

   function automatic logic is_space(input byte_type c);
      return (c == CHAR_SPACE) || (c >= 8'h09 && c <= 8'h0D);
   endfunction

   function automatic byte_type fold(input byte_type c);
      return (c >= 8'h41 && c <= 8'h5A) ? byte_type'(c + 8'h20) : c;
   endfunction

endpackage

`default_nettype wire

>>> rtl/core/wmf_match.sv
// Dictionary compare unit: checks one dictionary entry per cycle against
// the buffered word. Depends on wmf_pkg.
`default_nettype none

module wmf_match import wmf_pkg::*; (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire match_ctrl_type ctrl,
   input  wire word_buf_type   word_buf,
   input  wire logic [LEN_W-1:0] word_len,
   input  wire dict_type       dict,
   output match_stat_type      stat
);

   logic [ENT_W-1:0] ent_ff, ent_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic             hit_ff, hit_in;

   logic [DICT_W-1:0] entry;
   logic [DLEN_W-1:0] dlen;
   logic              seen;
   logic              entry_hit;

   // Length of the selected entry: bytes before the first zero
   always_comb begin
      entry = dict[ent_ff];
      dlen  = DLEN_W'(DICT_BYTES);
      seen  = 1'b0;
      for (int i = 0; i < DICT_BYTES; i++) begin
         if (!seen && entry[8*i +: 8] == 8'h00) begin
            dlen = DLEN_W'(i);
            seen = 1'b1;
         end
      end
   end

   // Byte compare with the incoming word folded to lower case
   always_comb begin
      entry_hit = (dlen != '0) && (dlen == DLEN_W'(word_len));
      for (int i = 0; i < MAX_WORD; i++) begin
         if (LEN_W'(i) < word_len && fold(word_buf[i]) != entry[8*i +: 8]) begin
            entry_hit = 1'b0;
         end
      end
   end

   // Entry sequencer, stops early on a hit
   always_comb begin
      ent_in  = ent_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      hit_in  = hit_ff;
      if (ctrl.start) begin
         ent_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (entry_hit || ent_ff == ENT_W'(MATCH_COUNT - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
            hit_in  = entry_hit;
         end else begin
            ent_in = ent_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ent_ff  <= '0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         hit_ff  <= 1'b0;
      end else begin
         ent_ff  <= ent_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
         hit_ff  <= hit_in;
      end
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign stat.hit  = hit_ff;

endmodule

`default_nettype wire

>>> rtl/core/word_mask_filter.sv
// Byte that only extends the buffered word: accepted without leaving idle, ready stays high.
// Word flush: the word is checked one dictionary entry a cycle in the shared compare unit, which then
// registers its verdict; each output beat then waits for the output register to be free.
// Beats leave from a single output register; ready returns as the last is loaded.
// Synchronous active-high reset restores the default dictionary and mask, empties the word and
// clears control state; the word buffer is not cleared. Needs wmf_pkg, wmf_match, defines.
`default_nettype none
`include "word_mask_filter_defines.svh"

module word_mask_filter import wmf_pkg::*; (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output      logic                 req_ready,
   input  wire logic [7:0]           req_char_in,
   input  wire logic                 req_line_end,
   output      logic                 rsp_valid,
   input  wire logic                 rsp_ready,
   output      logic [7:0]           rsp_char_out,
   output      logic                 rsp_last_of_run,
   output      logic                 rsp_line_done,
   input  wire logic                 csr_we,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [DICT_W-1:0]    csr_wdata
);

   wmf_state_type     state_ff, state_in;
   logic [LEN_W-1:0]  len_ff, len_in;
   logic              pass_ff, pass_in;
   logic              hit_ff, hit_in;
   logic [IDX_W-1:0]  idx_ff, idx_in;
   byte_type          tail_ff, tail_in;
   logic              nl_ff, nl_in;
   dict_type          dict_ff;
   byte_type          mask_ff;
   word_buf_type      buf_ff;

   logic              rsp_valid_ff, rsp_valid_in;
   byte_type          rsp_char_ff, rsp_char_in;
   logic              rsp_last_ff, rsp_last_in;
   logic              rsp_done_ff, rsp_done_in;

   logic              accept;
   logic              out_free;
   logic              buf_we;
   logic              emit;
   byte_type          emit_char;
   logic              emit_last;
   logic              emit_done;
   match_ctrl_type    m_ctrl;
   match_stat_type    m_stat;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   wmf_match u_match (
      .clock    (clock),
      .reset    (reset),
      .ctrl     (m_ctrl),
      .word_buf (buf_ff),
      .word_len (len_ff),
      .dict     (dict_ff),
      .stat     (m_stat)
   );

   // Sequencer: next state and beat selection
   always_comb begin
      state_in     = state_ff;
      len_in       = len_ff;
      pass_in      = pass_ff;
      hit_in       = hit_ff;
      idx_in       = idx_ff;
      tail_in      = tail_ff;
      nl_in        = nl_ff;
      buf_we       = 1'b0;
      m_ctrl.start = 1'b0;
      emit         = 1'b0;
      emit_char    = CHAR_SPACE;
      emit_last    = 1'b0;
      emit_done    = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_line_end) begin
                  pass_in = 1'b0;
                  nl_in   = 1'b1;
                  tail_in = CHAR_SPACE;
                  if (pass_ff) begin
                     state_in = ST_TAIL;
                  end else if (len_ff != '0) begin
                     m_ctrl.start = 1'b1;
                     state_in     = ST_MATCH;
                  end else begin
                     state_in = ST_NL;
                  end
               end else if (is_space(req_char_in)) begin
                  nl_in   = 1'b0;
                  tail_in = CHAR_SPACE;
                  if (pass_ff) begin
                     pass_in  = 1'b0;
                     state_in = ST_TAIL;
                  end else if (len_ff != '0) begin
                     m_ctrl.start = 1'b1;
                     state_in     = ST_MATCH;
                  end
               end else if (pass_ff) begin
                  nl_in    = 1'b0;
                  tail_in  = req_char_in;
                  state_in = ST_TAIL;
               end else if (len_ff < LEN_W'(MAX_WORD)) begin
                  buf_we = 1'b1;
                  len_in = len_ff + 1'b1;
               end else begin
                  // overlong word: echo the buffer unmasked, then this byte
                  hit_in   = 1'b0;
                  idx_in   = '0;
                  nl_in    = 1'b0;
                  tail_in  = req_char_in;
                  pass_in  = 1'b1;
                  state_in = ST_WORD;
               end
            end
         end
         ST_MATCH: begin
            if (m_stat.done) begin
               hit_in   = m_stat.hit;
               idx_in   = '0;
               state_in = ST_WORD;
            end
         end
         ST_WORD: begin
            if (out_free) begin
               emit      = 1'b1;
               emit_char = hit_ff ? mask_ff : buf_ff[idx_ff];
               if (LEN_W'(idx_ff) + LEN_W'(1) == len_ff) begin
                  len_in   = '0;
                  state_in = ST_TAIL;
               end else begin
                  idx_in = idx_ff + 1'b1;
               end
            end
         end
         ST_TAIL: begin
            if (out_free) begin
               emit      = 1'b1;
               emit_char = tail_ff;
               emit_last = !nl_ff;
               state_in  = nl_ff ? ST_NL : ST_IDLE;
            end
         end
         ST_NL: begin
            if (out_free) begin
               emit      = 1'b1;
               emit_char = CHAR_NEWLINE;
               emit_last = 1'b1;
               emit_done = 1'b1;
               len_in    = '0;
               pass_in   = 1'b0;
               state_in  = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Output register next values
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_char_in  = rsp_char_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_done_in  = rsp_done_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
         rsp_char_in  = emit_char;
         rsp_last_in  = emit_last;
         rsp_done_in  = emit_done;
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         len_ff       <= '0;
         pass_ff      <= 1'b0;
         hit_ff       <= 1'b0;
         idx_ff       <= '0;
         nl_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         len_ff       <= len_in;
         pass_ff      <= pass_in;
         hit_ff       <= hit_in;
         idx_ff       <= idx_in;
         nl_ff        <= nl_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      tail_ff     <= tail_in;
      rsp_char_ff <= rsp_char_in;
      rsp_last_ff <= rsp_last_in;
      rsp_done_ff <= rsp_done_in;
   end

   // Word buffer, written at the current length
   always_ff @(posedge clock) begin
      if (buf_we) begin
         buf_ff[len_ff[IDX_W-1:0]] <= req_char_in;
      end
   end

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         dict_ff[0] <= DICT_W'(64'd1801680230);
         dict_ff[1] <= DICT_W'(64'd1953065075);
         dict_ff[2] <= DICT_W'(64'd30809885393645433);
         dict_ff[3] <= '0;
         mask_ff    <= 8'h23;
      end else if (csr_we) begin
         if (csr_index < CSR_MASK) begin
            dict_ff[csr_index[1:0]] <= csr_wdata;
         end else if (csr_index == CSR_MASK) begin
            mask_ff <= csr_wdata[7:0];
         end
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_char_out    = rsp_char_ff;
   assign rsp_last_of_run = rsp_last_ff;
   assign rsp_line_done   = rsp_done_ff;

   `WMF_ASSERT(a_word_nonempty, (state_ff == ST_WORD) |-> (len_ff != '0), "flush of empty word")
   `WMF_NEVER(a_pass_empty, (state_ff == ST_IDLE) && pass_ff && (len_ff != '0), "bytes held in long word")
   `WMF_NEVER(a_len_range, len_ff > LEN_W'(MAX_WORD), "word length beyond buffer")
   `WMF_ASSERT(a_nl_beat, (rsp_valid_ff && rsp_done_ff) |-> (rsp_last_ff && rsp_char_ff == CHAR_NEWLINE), "line end beat malformed")
   `WMF_ASSERT(a_match_wait, (state_ff == ST_MATCH && !m_stat.done) |-> m_stat.busy, "match unit idle while awaited")

endmodule

`default_nettype wire

>>> verif/word_mask_filter_tb.sv
// Self-checking testbench for word_mask_filter: random text lines through valid/ready with gaps.
// A scoreboard class predicts the filtered bytes; depends on wmf_pkg and the word_mask_filter RTL.
`default_nettype none

module word_mask_filter_tb import wmf_pkg::*; ();

   localparam int CYCLE_LIMIT  = 1_000_000;
   localparam int DRAIN_CYCLES = 32;

   typedef byte_type text_type[$];

   typedef struct {
      byte_type ch;
      logic     last;
      logic     done;
   } out_beat_type;

   // Predicts the filtered stream and checks the block's output beats against it
   class mask_scoreboard;
      logic [DICT_W-1:0] dict[NUM_DICT_REGS];
      byte_type          mask;
      byte_type          word_buf[MAX_WORD];
      int                word_len;
      bit                in_long;
      byte_type          burst[$];
      out_beat_type      filtered_q[$];
      int                errors;

      function new();
         dict[0]  = 64'd1801680230;
         dict[1]  = 64'd1953065075;
         dict[2]  = 64'd30809885393645433;
         dict[3]  = 64'd0;
         mask     = 8'h23;
         word_len = 0;
         in_long  = 1'b0;
         errors   = 0;
      endfunction

      static function bit is_blank(byte_type c);
         return (c == CHAR_SPACE) || (c >= 8'h09 && c <= 8'h0D);
      endfunction

      static function byte_type lower_case(byte_type c);
         return (c >= 8'h41 && c <= 8'h5A) ? byte_type'(c + 8'h20) : c;
      endfunction

      function void set_reg(logic [CSR_IDX_W-1:0] idx, logic [DICT_W-1:0] val);
         if (idx == CSR_MASK)
            mask = val[7:0];
         else if (idx < CSR_DICT_0 + NUM_DICT_REGS)
            dict[idx - CSR_DICT_0] = val;
      endfunction

      // True when the buffered word equals one of the active dictionary entries
      function bit word_hits();
         int e, n, i;
         bit same;
         for (e = 0; e < MATCH_COUNT; e++) begin
            n = 0;
            while (n < DICT_BYTES && dict[e][8*n +: 8] != 8'h00) n++;
            if (n == 0 || n != word_len) continue;
            same = 1'b1;
            for (i = 0; i < n; i++)
               if (lower_case(word_buf[i]) != dict[e][8*i +: 8]) same = 1'b0;
            if (same) return 1'b1;
         end
         return 1'b0;
      endfunction

      function void flush_word();
         bit hit;
         int i;
         hit = word_hits();
         for (i = 0; i < word_len; i++) burst.insert(burst.size(), hit ? mask : word_buf[i]);
         word_len = 0;
      endfunction

      // One input beat: update state and queue the bytes it releases
      function void predict_filtered(byte_type ch, logic brk);
         out_beat_type b;
         bit closes;
         int i;
         burst.delete();
         closes = 1'b0;
         if (brk) begin
            if (in_long) begin
               burst.insert(burst.size(), CHAR_SPACE);
            end else if (word_len > 0) begin
               flush_word();
               burst.insert(burst.size(), CHAR_SPACE);
            end
            burst.insert(burst.size(), CHAR_NEWLINE);
            closes   = 1'b1;
            word_len = 0;
            in_long  = 1'b0;
         end else if (is_blank(ch)) begin
            if (in_long) begin
               burst.insert(burst.size(), CHAR_SPACE);
               in_long = 1'b0;
            end else if (word_len > 0) begin
               flush_word();
               burst.insert(burst.size(), CHAR_SPACE);
            end
         end else if (in_long) begin
            burst.insert(burst.size(), ch);
         end else if (word_len < MAX_WORD) begin
            word_buf[word_len] = ch;
            word_len++;
         end else begin
            // overlong word: release what was held, then echo from here on
            for (i = 0; i < word_len; i++) burst.insert(burst.size(), word_buf[i]);
            burst.insert(burst.size(), ch);
            word_len = 0;
            in_long  = 1'b1;
         end
         for (i = 0; i < burst.size(); i++) begin
            b.ch   = burst[i];
            b.last = (i == burst.size() - 1);
            b.done = closes && (i == burst.size() - 1);
            filtered_q.insert(filtered_q.size(), b);
         end
      endfunction

      function void check_filtered(byte_type ch, logic last, logic done);
         out_beat_type want;
         if (filtered_q.size() == 0) begin
            $display("%0t: beat with nothing expected: char_out %h last_of_run %b line_done %b",
                     $time, ch, last, done);
            errors++;
            return;
         end
         want = filtered_q.pop_front();
         if (ch !== want.ch) begin
            $display("%0t: char_out expected %h actual %h", $time, want.ch, ch);
            errors++;
         end
         if (last !== want.last) begin
            $display("%0t: last_of_run expected %b actual %b", $time, want.last, last);
            errors++;
         end
         if (done !== want.done) begin
            $display("%0t: line_done expected %b actual %b", $time, want.done, done);
            errors++;
         end
      endfunction

      function int pending();
         return filtered_q.size();
      endfunction
   endclass

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   logic [7:0]           req_char_in = 8'h00;
   logic                 req_line_end = 1'b0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   logic [7:0]           rsp_char_out;
   logic                 rsp_last_of_run;
   logic                 rsp_line_done;
   logic                 csr_we = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = CSR_DICT_0;
   logic [DICT_W-1:0]    csr_wdata = '0;

   mask_scoreboard sb;
   bit             calm = 1'b0;
   int             beats_sent = 0;
   int             stall_left = 0;
   int             cycles = 0;

   word_mask_filter uut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_char_in     (req_char_in),
      .req_line_end    (req_line_end),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_char_out    (rsp_char_out),
      .rsp_last_of_run (rsp_last_of_run),
      .rsp_line_done   (rsp_line_done),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Mostly short gaps, a few long ones, none during calm lines
   function automatic int pick_gap();
      int r;
      if (calm) return 0;
      r = $urandom_range(99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // Output side back-pressure
   always @(posedge clock) begin
      if (stall_left > 0) begin
         rsp_ready  <= 1'b0;
         stall_left <= stall_left - 1;
      end else begin
         rsp_ready  <= 1'b1;
         stall_left <= pick_gap();
      end
   end

   // Beat monitor: predict on accepted input, check on accepted output
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) sb.predict_filtered(req_char_in, req_line_end);
         if (rsp_valid && rsp_ready)
            sb.check_filtered(rsp_char_out, rsp_last_of_run, rsp_line_done);
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   task automatic send_beat(input byte_type ch, input logic brk);
      int gap;
      req_valid    <= 1'b1;
      req_char_in  <= ch;
      req_line_end <= brk;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      beats_sent++;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid   <= 1'b0;
         req_char_in <= byte_type'($urandom);
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic send_text(input text_type t);
      int i;
      for (i = 0; i < t.size(); i++) send_beat(t[i], 1'b0);
   endtask

   task automatic send_blank_run();
      int n, r;
      n = $urandom_range(1, 3);
      repeat (n) begin
         r = $urandom_range(5);
         send_beat((r == 5) ? CHAR_SPACE : byte_type'(8'h09 + r), 1'b0);
      end
   endtask

   // Text of dictionary entry e; letters either random case or all upper case
   function automatic text_type dict_text(input int e, input bit upper);
      text_type w;
      byte_type b;
      int i;
      for (i = 0; i < DICT_BYTES; i++) begin
         b = sb.dict[e][8*i +: 8];
         if (b == 8'h00) break;
         if (b >= 8'h61 && b <= 8'h7A && (upper || $urandom_range(1) == 1))
            b = byte_type'(b - 8'h20);
         w.insert(w.size(), b);
      end
      return w;
   endfunction

   function automatic byte_type any_letter();
      return byte_type'(($urandom_range(1) ? 8'h41 : 8'h61) + $urandom_range(25));
   endfunction

   function automatic byte_type any_solid();
      byte_type b;
      do b = byte_type'($urandom); while (mask_scoreboard::is_blank(b));
      return b;
   endfunction

   function automatic text_type pick_word();
      text_type w;
      int kind, n, i;
      kind = $urandom_range(99);
      if (kind < 55) begin
         w = dict_text($urandom_range(NUM_DICT_REGS - 1), 1'b0);
         // near miss: one byte short, one too many, or one changed
         if (kind >= 40 && w.size() > 0) begin
            case ($urandom_range(2))
               0: w.pop_back();
               1: w.insert(w.size(), byte_type'(8'h61 + $urandom_range(25)));
               default: w[$urandom_range(w.size() - 1)] = byte_type'(8'h61 + $urandom_range(25));
            endcase
         end
      end else if (kind < 80) begin
         n = $urandom_range(1, MAX_WORD);
         for (i = 0; i < n; i++) w.insert(w.size(), any_letter());
      end else if (kind < 90) begin
         n = $urandom_range(1, MAX_WORD);
         for (i = 0; i < n; i++) w.insert(w.size(), any_solid());
      end else begin
         n = $urandom_range(MAX_WORD + 1, MAX_WORD + 6);
         for (i = 0; i < n; i++) w.insert(w.size(), any_solid());
      end
      if (w.size() == 0) w.insert(w.size(), any_letter());
      return w;
   endfunction

   // One line: words split by whitespace runs, odd noise bytes, then line end
   task automatic send_line();
      int words, k;
      calm  = ($urandom_range(3) == 0);
      words = $urandom_range(0, 5);
      if ($urandom_range(3) == 0) send_blank_run();
      for (k = 0; k < words; k++) begin
         if ($urandom_range(19) == 0) send_beat(byte_type'($urandom), 1'b0);
         send_text(pick_word());
         if (k < words - 1 || $urandom_range(1) == 0) send_blank_run();
      end
      send_beat(byte_type'($urandom), 1'b1);
   endtask

   task automatic run_lines(input int count);
      int stop;
      stop = beats_sent + count;
      while (beats_sent < stop) send_line();
      calm = 1'b0;
   endtask

   // Wait until every expected beat is out and the block has settled
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [DICT_W-1:0] val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      sb.set_reg(idx, val);
      @(posedge clock);
   endtask

   function automatic logic [DICT_W-1:0] make_entry(input int len);
      logic [DICT_W-1:0] v;
      int i;
      v = '0;
      for (i = 0; i < len; i++) v[8*i +: 8] = byte_type'(8'h61 + $urandom_range(25));
      return v;
   endfunction

   task automatic load_dict(input logic [DICT_W-1:0] w0, input logic [DICT_W-1:0] w1,
                            input logic [DICT_W-1:0] w2, input logic [DICT_W-1:0] w3,
                            input byte_type mask_byte);
      write_reg(CSR_IDX_W'(CSR_DICT_0 + 0), w0);
      write_reg(CSR_IDX_W'(CSR_DICT_0 + 1), w1);
      write_reg(CSR_IDX_W'(CSR_DICT_0 + 2), w2);
      write_reg(CSR_IDX_W'(CSR_DICT_0 + 3), w3);
      // upper bits of the mask write are don't-care
      write_reg(CSR_MASK, {32'($urandom), 24'($urandom), mask_byte});
      csr_we <= 1'b0;
   endtask

   initial begin
      logic [DICT_W-1:0] odd_entry;
      sb = new();
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Directed beats on the reset dictionary
      send_beat(8'hFF, 1'b1);                    // empty line, char ignored
      send_beat(CHAR_SPACE, 1'b0);               // whitespace with no word pending
      send_beat(8'h09, 1'b0);
      send_beat(8'h0D, 1'b0);
      send_text(dict_text(0, 1'b1));             // upper-case dictionary hit
      send_beat(CHAR_NEWLINE, 1'b0);             // newline byte acts as a separator
      send_text('{8'hFF, 8'h00, 8'h80, 8'h40, 8'h5B, 8'h5A, 8'h60, 8'h7A, 8'h21, 8'h01});
      send_beat(8'h00, 1'b1);                    // overlong word closed by line end
      send_text(dict_text(2, 1'b0));
      send_beat(CHAR_SPACE, 1'b1);               // flush of a hit at line end
      run_lines(100);
      drain();

      // Full-length entry, one-letter entry, an unused slot, fourth slot active, zero mask
      load_dict(make_entry(8), make_entry(1), '0, make_entry($urandom_range(2, 7)), 8'h00);
      run_lines(100);
      drain();

      // All-ones entry, zero byte inside an entry ("ab" then "cd"), upper-case entry
      odd_entry = make_entry($urandom_range(2, 6));
      odd_entry[7:0] = byte_type'(odd_entry[7:0] - 8'h20);
      load_dict({DICT_W{1'b1}}, 64'h0000_0064_6300_6261,
                odd_entry, make_entry($urandom_range(1, 8)), 8'hFF);
      run_lines(100);
      drain();

      if (sb.errors == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

`default_nettype wire
